FILE: design/trimmed_mean_window_filter_defines.svh
// ---------------------------------------------------------------------------
// Trimmed mean window filter assertion macros
// Shared property macros; clk and arst_n are taken from the calling module.
// ---------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_WINDOW_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_DEFINES_SVH

// same-cycle implication
`define TMWF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMWF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/tmwf_pkg.sv
// ---------------------------------------------------------------------------
// tmwf_pkg
// Types and fixed constants shared by the trimmed mean window filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmwf_pkg;

	localparam int OUT_WIDTH      = 16;
	localparam int CNT_OUT_WIDTH  = 4;
	localparam int MIN_TRIM_COUNT = 3;
	localparam int TRIM_DROP      = 2;

	typedef struct packed {
		logic done;
		logic bypass;
	} win_stat_t;

endpackage

FILE: design/tmwf_window.sv
// ---------------------------------------------------------------------------
// tmwf_window
// Sample ring memory with fill count; walks held samples one per cycle to
// form sum, minimum and maximum, then the trimmed sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmwf_window #(
	parameter int WINDOW       = 8,
	parameter int SAMPLE_WIDTH = 16,
	localparam int CW          = $clog2(WINDOW + 1),
	localparam int SUMW        = SAMPLE_WIDTH + CW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [SAMPLE_WIDTH-1:0] push_data,
	output tmwf_pkg::win_stat_t     stat,
	output logic [SUMW-1:0]         trim_sum,
	output logic [SAMPLE_WIDTH-1:0] newest,
	output logic [CW-1:0]           count
);

	import tmwf_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam logic [AW-1:0] LAST_POS = AW'(WINDOW - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);
	localparam logic [CW-1:0] TRIM_MIN = CW'(MIN_TRIM_COUNT);

	logic [SAMPLE_WIDTH-1:0] mem [WINDOW];

	logic [AW-1:0]           wr_pos_q;
	logic [AW-1:0]           old_pos_q;
	logic [CW-1:0]           fill_q;
	logic [SAMPLE_WIDTH-1:0] newest_q;
	logic                    walk_q;
	logic [AW-1:0]           rd_ptr_q;
	logic [CW-1:0]           issued_q;
	logic                    rd_vld_s1;
	logic                    rd_last_s1;
	logic [SAMPLE_WIDTH-1:0] rd_data_s1;
	logic [SUMW-1:0]         acc_q;
	logic [SAMPLE_WIDTH-1:0] lo_q;
	logic [SAMPLE_WIDTH-1:0] hi_q;
	logic                    fin1_q;
	logic                    fin2_q;
	logic                    done_q;
	logic                    bypass_q;

	logic                    full;
	logic [AW-1:0]           wr_pos_nxt;
	logic [AW-1:0]           old_pos_nxt;
	logic [AW-1:0]           rd_ptr_nxt;
	logic [CW-1:0]           fill_nxt;
	logic                    last_issue;

	assign full        = (fill_q == FULL_CNT);
	assign wr_pos_nxt  = (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + 1'b1;
	assign old_pos_nxt = (old_pos_q == LAST_POS) ? '0 : old_pos_q + 1'b1;
	assign rd_ptr_nxt  = (rd_ptr_q == LAST_POS) ? '0 : rd_ptr_q + 1'b1;
	assign fill_nxt    = full ? FULL_CNT : fill_q + 1'b1;
	assign last_issue  = (issued_q == fill_q - 1'b1);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_pos_q] <= push_data;
		end
		if (walk_q) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q   <= '0;
			old_pos_q  <= '0;
			fill_q     <= '0;
			newest_q   <= '0;
			walk_q     <= 1'b0;
			rd_ptr_q   <= '0;
			issued_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			acc_q      <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			fin1_q     <= 1'b0;
			fin2_q     <= 1'b0;
			done_q     <= 1'b0;
			bypass_q   <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			fin1_q     <= 1'b0;
			fin2_q     <= 1'b0;
			rd_vld_s1  <= walk_q;
			rd_last_s1 <= walk_q && last_issue;

			if (push) begin
				wr_pos_q <= wr_pos_nxt;
				fill_q   <= fill_nxt;
				newest_q <= push_data;
				if (full) begin
					old_pos_q <= old_pos_nxt;
				end
				if (fill_nxt < TRIM_MIN) begin
					done_q   <= 1'b1;
					bypass_q <= 1'b1;
				end else begin
					bypass_q <= 1'b0;
					walk_q   <= 1'b1;
					rd_ptr_q <= full ? old_pos_nxt : old_pos_q;
					issued_q <= '0;
					acc_q    <= '0;
					lo_q     <= '1;
					hi_q     <= '0;
				end
			end

			if (walk_q) begin
				rd_ptr_q <= rd_ptr_nxt;
				issued_q <= issued_q + 1'b1;
				if (last_issue) begin
					walk_q <= 1'b0;
				end
			end

			if (rd_vld_s1) begin
				acc_q <= acc_q + SUMW'(rd_data_s1);
				if (rd_data_s1 < lo_q) begin
					lo_q <= rd_data_s1;
				end
				if (rd_data_s1 > hi_q) begin
					hi_q <= rd_data_s1;
				end
				fin1_q <= rd_last_s1;
			end

			if (fin1_q) begin
				acc_q  <= acc_q - SUMW'(hi_q);
				fin2_q <= 1'b1;
			end

			if (fin2_q) begin
				acc_q  <= acc_q - SUMW'(lo_q);
				done_q <= 1'b1;
			end
		end
	end

	assign stat.done   = done_q;
	assign stat.bypass = bypass_q;
	assign trim_sum    = acc_q;
	assign newest      = newest_q;
	assign count       = fill_q;

endmodule

FILE: design/tmwf_divider.sv
// ---------------------------------------------------------------------------
// tmwf_divider
// Bit-serial restoring divider: one quotient bit per cycle, shifted through
// the dividend register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmwf_divider #(
	parameter int WINDOW       = 8,
	parameter int SAMPLE_WIDTH = 16,
	localparam int CW          = $clog2(WINDOW + 1),
	localparam int SUMW        = SAMPLE_WIDTH + CW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SUMW-1:0]         dividend,
	input  logic [CW-1:0]           divisor,
	output logic                    done,
	output logic [SAMPLE_WIDTH-1:0] quotient
);

	localparam int SCW = $clog2(SAMPLE_WIDTH + 1);

	logic [CW-1:0]           rem_q;
	logic [SAMPLE_WIDTH-1:0] quo_q;
	logic [CW-1:0]           div_q;
	logic [SCW-1:0]          step_q;
	logic                    busy_q;
	logic                    done_q;

	logic [CW:0]             trial;
	logic [CW:0]             diff;
	logic                    fits;

	assign trial = {rem_q, quo_q[SAMPLE_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// quotient fits SAMPLE_WIDTH bits, so the top bits already lie below the divisor
				rem_q  <= dividend[SUMW-1:SAMPLE_WIDTH];
				quo_q  <= dividend[SAMPLE_WIDTH-1:0];
				div_q  <= divisor;
				step_q <= SCW'(SAMPLE_WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? diff[CW-1:0] : trial[CW-1:0];
				quo_q  <= {quo_q[SAMPLE_WIDTH-2:0], fits};
				step_q <= step_q - 1'b1;
				if (step_q == SCW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`include "trimmed_mean_window_filter_defines.svh"

	`TMWF_ASSERT_SAME(a_div_no_restart, start, !busy_q, "divider restarted while busy")
	`TMWF_ASSERT_NEXT(a_div_rem_below, busy_q, rem_q < div_q || !busy_q, "remainder reached divisor")
	`TMWF_ASSERT_SAME(a_div_done_idle, done_q, !busy_q, "divider done while busy")

endmodule

FILE: design/trimmed_mean_window_filter.sv
// A new sample is taken only in idle, after the previous result is loaded for output;
// while fewer than three samples are held, the window walk and the divide are skipped.
// Result timing is set by the window walk (one memory read per cycle) and the bit-serial
// divider (one quotient bit per cycle).
// Reset: arst_n clears the fill count and positions; ring memory contents are not cleared.
// ---------------------------------------------------------------------------
// trimmed_mean_window_filter
// Mean of held samples with min and max dropped; below three held, the newest passes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trimmed_mean_window_filter #(
	parameter int WINDOW       = 8,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [15:0]                        sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tmwf_pkg::OUT_WIDTH-1:0]     filtered,
	output logic [tmwf_pkg::CNT_OUT_WIDTH-1:0] held_count
);

	import tmwf_pkg::*;

	localparam int CW   = $clog2(WINDOW + 1);
	localparam int SUMW = SAMPLE_WIDTH + CW;
	localparam logic [CW-1:0] TRIM_MIN = CW'(MIN_TRIM_COUNT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	logic [1:0]                state_q;
	logic [SAMPLE_WIDTH-1:0]   res_q;
	logic                      out_valid_q;
	logic [OUT_WIDTH-1:0]      filt_q;
	logic [CNT_OUT_WIDTH-1:0]  held_q;

	logic                      in_accept;
	logic [31:0]               sample_ext;
	logic [SAMPLE_WIDTH-1:0]   push_data;
	win_stat_t                 stat;
	logic [SUMW-1:0]           trim_sum;
	logic [SAMPLE_WIDTH-1:0]   newest;
	logic [CW-1:0]             count;
	logic                      div_start;
	logic                      div_done;
	logic [SAMPLE_WIDTH-1:0]   quotient;
	logic                      out_load;
	logic [31:0]               res_ext;
	logic [7:0]                cnt_ext;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_accept  = in_valid && in_ready;
	assign sample_ext = 32'(sample);
	assign push_data  = sample_ext[SAMPLE_WIDTH-1:0];
	assign div_start  = (state_q == ST_WALK) && stat.done && !stat.bypass;
	assign out_load   = (state_q == ST_RES) && (!out_valid_q || out_ready);
	assign res_ext    = 32'(res_q);
	assign cnt_ext    = 8'(count);

	tmwf_window #(
		.WINDOW       (WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (push_data),
		.stat      (stat),
		.trim_sum  (trim_sum),
		.newest    (newest),
		.count     (count)
	);

	tmwf_divider #(
		.WINDOW       (WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (trim_sum),
		.divisor  (count - CW'(TRIM_DROP)),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			filt_q      <= '0;
			held_q      <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (stat.done) begin
						if (stat.bypass) begin
							res_q   <= newest;
							state_q <= ST_RES;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_q   <= quotient;
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						filt_q      <= res_ext[OUT_WIDTH-1:0];
						held_q      <= cnt_ext[CNT_OUT_WIDTH-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign filtered   = filt_q;
	assign held_count = held_q;

	`include "trimmed_mean_window_filter_defines.svh"

	`TMWF_ASSERT_SAME(a_win_done_walk, stat.done, state_q == ST_WALK, "window done outside walk")
	`TMWF_ASSERT_SAME(a_div_done_div, div_done, state_q == ST_DIV, "divider done outside divide")
	`TMWF_ASSERT_SAME(a_bypass_small, stat.done, stat.bypass == (count < TRIM_MIN), "bypass mismatch")
	`TMWF_ASSERT_NEXT(a_out_drain, out_valid_q && out_ready && !out_load, !out_valid_q, "transaction not retired")

endmodule
